@@ design/dht_pkg.sv @@
// Shared types, constants and helper functions for the double hashing table.
`timescale 1ns / 1ps

package dht_pkg;

    // Table geometry
    localparam int SLOTS    = 11;
    localparam int STEP_MOD = 7;
    localparam int KEY_W    = 31;
    localparam int CMD_W    = 2;
    localparam int RES_W    = 3;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int REMM_W   = (STEP_MOD > 2) ? $clog2(STEP_MOD) : 1;

    // Key is reduced one byte per cycle, most significant byte first
    localparam int DIG_W    = 8;
    localparam int NDIG     = (KEY_W + DIG_W - 1) / DIG_W;
    localparam int KEYPAD_W = NDIG * DIG_W;
    localparam int DCNT_W   = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic [DIG_W-1:0]  SLOTS_B   = DIG_W'(SLOTS);
    localparam logic [DIG_W-1:0]  STEP_B    = DIG_W'(STEP_MOD);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NDIG - 1);

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef enum logic [RES_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_FULL      = 3'd1,
        RES_REMOVED   = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_FOUND     = 3'd4
    } res_t;

    typedef enum logic [1:0] {
        SS_EMPTY   = 2'd0,
        SS_USED    = 2'd1,
        SS_DELETED = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SETUP,
        ST_PROBE,
        ST_HOLD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture request
        logic mod_step;    // fold one key byte into both remainders
        logic probe_init;  // set home slot and step
        logic probe_step;  // advance probe pipeline
        logic ins_write;   // store key at current probe slot
        logic del_write;   // mark matched slot deleted
    } dht_ctl_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic mod_last;    // last key byte this cycle
        logic home_empty;  // first probe hits a never-used slot
        logic a_free;      // current probe slot is empty or deleted
        logic a_last;      // current probe is the final one
        logic b_match;     // previous probe slot holds the key
        logic b_last;      // previous probe was the final one
    } dht_stat_t;

    // Remainder of v by m, valid for v < 256*m: eight conditional subtracts
    function automatic logic [DIG_W-1:0] mod_byte(input logic [2*DIG_W-1:0] v,
                                                   input logic [DIG_W-1:0] m);
        logic [2*DIG_W-1:0] r;
        logic [2*DIG_W-1:0] d;
        r = v;
        for (int k = DIG_W - 1; k >= 0; k--) begin
            d = (2*DIG_W)'(m) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[DIG_W-1:0];
    endfunction

endpackage

@@ design/dht_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/dht_dp.sv @@
// Datapath: key reduction, probe address generation, slot status and key store.
`timescale 1ns / 1ps

module dht_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dht_pkg::dht_ctl_t            ctl,
    input  logic [dht_pkg::CMD_W-1:0]    in_cmd,
    input  logic [dht_pkg::KEY_W-1:0]    in_key,
    output dht_pkg::dht_stat_t           stat
);

    // Request registers
    dht_pkg::op_t                    op_reg;
    logic [dht_pkg::KEY_W-1:0]       key_reg;
    logic [dht_pkg::DCNT_W-1:0]      dcnt_reg;
    logic [dht_pkg::SLOT_W-1:0]      rem_s_reg;
    logic [dht_pkg::REMM_W-1:0]      rem_m_reg;

    // Probe stage A: address issue
    logic [dht_pkg::SLOT_W-1:0]      slot_reg;
    logic [dht_pkg::SLOT_W-1:0]      step_reg;
    logic [dht_pkg::SLOT_W-1:0]      pcnt_reg;
    logic                            a_active_reg;

    // Probe stage B: key compare
    logic                            b_valid_reg;
    logic                            b_used_reg;
    logic                            b_last_reg;
    logic [dht_pkg::SLOT_W-1:0]      b_slot_reg;

    dht_pkg::slot_state_t            slot_status_reg [dht_pkg::SLOTS];

    logic [dht_pkg::KEYPAD_W-1:0]    key_pad;
    logic [dht_pkg::DCNT_W-1:0]      dsel;
    logic [dht_pkg::DIG_W-1:0]       digit;
    logic [dht_pkg::DIG_W-1:0]       rem_s_wide;
    logic [dht_pkg::DIG_W-1:0]       rem_m_wide;
    logic [dht_pkg::DIG_W-1:0]       step_raw;
    logic [dht_pkg::DIG_W-1:0]       step_red;
    logic [dht_pkg::SLOT_W:0]        slot_sum;
    logic [dht_pkg::SLOT_W-1:0]      slot_next;
    logic [dht_pkg::KEY_W-1:0]       ram_rdata;
    dht_pkg::slot_state_t            a_state;

    // Byte select, most significant first
    assign key_pad = dht_pkg::KEYPAD_W'(key_reg);
    assign dsel    = dht_pkg::DCNT_LAST - dcnt_reg;
    assign digit   = key_pad[dsel*dht_pkg::DIG_W +: dht_pkg::DIG_W];

    // Remainders extended by one byte
    assign rem_s_wide = dht_pkg::mod_byte({dht_pkg::DIG_W'(rem_s_reg), digit},
                                          dht_pkg::SLOTS_B);
    assign rem_m_wide = dht_pkg::mod_byte({dht_pkg::DIG_W'(rem_m_reg), digit},
                                          dht_pkg::STEP_B);

    // Step in 1..STEP_MOD, folded below SLOTS
    assign step_raw = dht_pkg::STEP_B - dht_pkg::DIG_W'(rem_m_reg);
    assign step_red = dht_pkg::mod_byte({dht_pkg::DIG_W'(0), step_raw},
                                        dht_pkg::SLOTS_B);

    // Next probe slot, one compare and subtract
    assign slot_sum  = {1'b0, slot_reg} + {1'b0, step_reg};
    assign slot_next = (slot_sum >= (dht_pkg::SLOT_W+1)'(dht_pkg::SLOTS)) ?
                       dht_pkg::SLOT_W'(slot_sum - (dht_pkg::SLOT_W+1)'(dht_pkg::SLOTS)) :
                       slot_sum[dht_pkg::SLOT_W-1:0];

    assign a_state = slot_status_reg[slot_reg];

    // Key store
    dht_ram #(
        .WIDTH (dht_pkg::KEY_W),
        .DEPTH (dht_pkg::SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ctl.ins_write),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Status to controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.mod_last   = (dcnt_reg == dht_pkg::DCNT_LAST);
        stat.home_empty = a_active_reg && (pcnt_reg == '0) && (a_state == dht_pkg::SS_EMPTY);
        stat.a_free     = a_active_reg && (a_state != dht_pkg::SS_USED);
        stat.a_last     = a_active_reg && (pcnt_reg == dht_pkg::SLOT_LAST);
        stat.b_match    = b_valid_reg && b_used_reg && (ram_rdata == key_reg);
        stat.b_last     = b_valid_reg && b_last_reg;
    end

    // Request capture and key reduction
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= dht_pkg::op_t'(in_cmd);
            key_reg   <= in_key;
            dcnt_reg  <= '0;
            rem_s_reg <= '0;
            rem_m_reg <= '0;
        end
        else if (ctl.mod_step)
        begin
            dcnt_reg  <= dcnt_reg + 1'b1;
            rem_s_reg <= dht_pkg::SLOT_W'(rem_s_wide);
            rem_m_reg <= dht_pkg::REMM_W'(rem_m_wide);
        end
    end

    // Probe address and counters
    always_ff @(posedge clk)
    begin
        if (ctl.probe_init)
        begin
            slot_reg <= rem_s_reg;
            step_reg <= dht_pkg::SLOT_W'(step_red);
            pcnt_reg <= '0;
        end
        else if (ctl.probe_step && a_active_reg)
        begin
            slot_reg <= slot_next;
            if (pcnt_reg != dht_pkg::SLOT_LAST)
            begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end
        end
        if (ctl.probe_step)
        begin
            b_slot_reg <= slot_reg;
            b_used_reg <= (a_state == dht_pkg::SS_USED);
            b_last_reg <= (pcnt_reg == dht_pkg::SLOT_LAST);
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_active_reg <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else if (ctl.probe_init)
        begin
            a_active_reg <= 1'b1;
            b_valid_reg  <= 1'b0;
        end
        else if (ctl.probe_step)
        begin
            b_valid_reg <= a_active_reg;
            if (pcnt_reg == dht_pkg::SLOT_LAST)
            begin
                a_active_reg <= 1'b0;
            end
        end
    end

    // Slot status flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dht_pkg::SLOTS; i++)
            begin
                slot_status_reg[i] <= dht_pkg::SS_EMPTY;
            end
        end
        else if (ctl.ins_write)
        begin
            slot_status_reg[slot_reg] <= dht_pkg::SS_USED;
        end
        else if (ctl.del_write)
        begin
            slot_status_reg[b_slot_reg] <= dht_pkg::SS_DELETED;
        end
    end

    // Checks
    a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_write |-> (a_active_reg && a_state != dht_pkg::SS_USED))
        else $error("insert into a used slot");

    a_del_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.del_write |-> (b_valid_reg && b_used_reg && ram_rdata == key_reg))
        else $error("delete without key match");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_active_reg |-> (slot_reg <= dht_pkg::SLOT_LAST))
        else $error("probe slot out of range");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins_write && ctl.del_write))
        else $error("insert and delete in one cycle");

endmodule

@@ design/dht_ctrl.sv @@
// Controller: request sequencing state machine and result register.
`timescale 1ns / 1ps

module dht_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dht_pkg::RES_W-1:0]   status,
    output dht_pkg::dht_ctl_t           ctl,
    input  dht_pkg::dht_stat_t          stat
);

    dht_pkg::state_t state_reg, state_next;
    dht_pkg::res_t   res_reg, res_next;
    dht_pkg::res_t   status_reg, status_next;
    logic            out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == dht_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dht_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dht_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = dht_pkg::ST_MOD;
                end
            end
            dht_pkg::ST_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = dht_pkg::ST_SETUP;
                end
            end
            dht_pkg::ST_SETUP:
            begin
                if (stat.op == dht_pkg::OP_BAD)
                begin
                    res_next   = dht_pkg::RES_NOT_FOUND;
                    state_next = dht_pkg::ST_HOLD;
                end
                else
                begin
                    ctl.probe_init = 1'b1;
                    state_next     = dht_pkg::ST_PROBE;
                end
            end
            dht_pkg::ST_PROBE:
            begin
                case (stat.op) inside
                    dht_pkg::OP_INSERT:
                    begin
                        if (stat.a_free)
                        begin
                            ctl.ins_write = 1'b1;
                            res_next      = dht_pkg::RES_INSERTED;
                            state_next    = dht_pkg::ST_HOLD;
                        end
                        else if (stat.a_last)
                        begin
                            res_next   = dht_pkg::RES_FULL;
                            state_next = dht_pkg::ST_HOLD;
                        end
                        else
                        begin
                            ctl.probe_step = 1'b1;
                        end
                    end
                    dht_pkg::OP_REMOVE, dht_pkg::OP_SEARCH:
                    begin
                        if (stat.home_empty)
                        begin
                            res_next   = dht_pkg::RES_NOT_FOUND;
                            state_next = dht_pkg::ST_HOLD;
                        end
                        else if (stat.b_match)
                        begin
                            if (stat.op == dht_pkg::OP_REMOVE)
                            begin
                                ctl.del_write = 1'b1;
                                res_next      = dht_pkg::RES_REMOVED;
                            end
                            else
                            begin
                                res_next = dht_pkg::RES_FOUND;
                            end
                            state_next = dht_pkg::ST_HOLD;
                        end
                        else if (stat.b_last)
                        begin
                            res_next   = dht_pkg::RES_NOT_FOUND;
                            state_next = dht_pkg::ST_HOLD;
                        end
                        else
                        begin
                            ctl.probe_step = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_next   = dht_pkg::RES_NOT_FOUND;
                        state_next = dht_pkg::ST_HOLD;
                    end
                endcase
            end
            dht_pkg::ST_HOLD:
            begin
                // Wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    state_next     = dht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dht_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == dht_pkg::ST_MOD))
        else $error("request accepted outside idle");

    a_hold_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dht_pkg::ST_HOLD && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && status_reg == $past(res_reg)))
        else $error("result not loaded into output register");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.ins_write || ctl.del_write) |=> (state_reg == dht_pkg::ST_HOLD))
        else $error("table write without finishing request");

endmodule

@@ design/double_hash_table.sv @@
// Top level of the 11-slot open addressing hash table with double hashing.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: cmd (insert,
//   remove, search) and a 31-bit key. Output channel (out_valid/out_ready)
//   returns one 3-bit status per request, in request order.
//   A request is accepted only while the controller is idle. The key is
//   reduced mod 11 and mod 7 one byte per cycle, the setup state prepares
//   the probe, then the probe sequencer visits one slot per cycle; the
//   key store RAM has a registered read, so lookups compare in the cycle
//   after the address. The hold state then loads the output register.
//   A new request is accepted only once the previous one has left the hold
//   state; the byte-serial key reduction and the one-slot-per-cycle probe
//   loop set the pace.
//   Reset clears all slot status to empty at once; the key store holds no
//   reset value and needs no clearing pass.
//   While out_ready is low the finished status waits in the output register
//   and the next request is still accepted; if that one finishes too, it
//   waits internally until the output register is taken.
`timescale 1ns / 1ps

module double_hash_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dht_pkg::CMD_W-1:0]   cmd,
    input  logic [dht_pkg::KEY_W-1:0]   key,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dht_pkg::RES_W-1:0]   status
);

    dht_pkg::dht_ctl_t  ctl;
    dht_pkg::dht_stat_t stat;

    dht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctl       (ctl),
        .stat      (stat)
    );

    dht_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .in_cmd (cmd),
        .in_key (key),
        .stat   (stat)
    );

endmodule

@@ test/tb_double_hash_table.sv @@
// Self-checking testbench for the double hashing table: directed and random requests.
`timescale 1ns / 1ps

module tb_double_hash_table;

    localparam int N_RANDOM   = 2000;
    localparam int N_PHASES   = 4;
    localparam int POOL_SIZE  = 12;
    localparam int POOL_RENEW = 250;
    localparam int DRAIN_CYC  = 40;

    // One row of the directed table; typed rows carry their own expected status
    typedef struct {
        dht_pkg::op_t              op;
        logic [dht_pkg::KEY_W-1:0] k;
        bit                        typed;
        dht_pkg::res_t             res;
    } dir_row_t;

    localparam int N_DIRECTED = 25;

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{dht_pkg::OP_SEARCH, 31'd5,         1'b1, dht_pkg::RES_NOT_FOUND},  // empty table
        '{dht_pkg::OP_REMOVE, 31'd5,         1'b1, dht_pkg::RES_NOT_FOUND},
        '{dht_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b1, dht_pkg::RES_INSERTED},   // largest key
        '{dht_pkg::OP_SEARCH, 31'h7FFF_FFFF, 1'b1, dht_pkg::RES_FOUND},
        '{dht_pkg::OP_BAD,    31'h7FFF_FFFF, 1'b1, dht_pkg::RES_NOT_FOUND},  // unknown command
        '{dht_pkg::OP_INSERT, 31'd0,         1'b1, dht_pkg::RES_INSERTED},   // key zero
        '{dht_pkg::OP_SEARCH, 31'd0,         1'b1, dht_pkg::RES_FOUND},
        '{dht_pkg::OP_REMOVE, 31'd0,         1'b1, dht_pkg::RES_REMOVED},
        '{dht_pkg::OP_SEARCH, 31'd0,         1'b0, dht_pkg::RES_NOT_FOUND},  // home deleted
        '{dht_pkg::OP_REMOVE, 31'h7FFF_FFFF, 1'b1, dht_pkg::RES_REMOVED},
        // keys sharing home slot 0, filling the whole table
        '{dht_pkg::OP_INSERT, 31'd11,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd22,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd33,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd44,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd55,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd66,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd77,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd88,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd99,        1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd110,       1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'd121,       1'b0, dht_pkg::RES_INSERTED},
        '{dht_pkg::OP_INSERT, 31'h5555_5555, 1'b1, dht_pkg::RES_FULL},       // no free slot
        '{dht_pkg::OP_SEARCH, 31'd121,       1'b0, dht_pkg::RES_FOUND},
        '{dht_pkg::OP_REMOVE, 31'd66,        1'b0, dht_pkg::RES_REMOVED},
        '{dht_pkg::OP_INSERT, 31'h2AAA_AAAA, 1'b0, dht_pkg::RES_INSERTED}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [dht_pkg::CMD_W-1:0] cmd;
    logic [dht_pkg::KEY_W-1:0] key;
    logic                      out_valid;
    logic                      out_ready;
    logic [dht_pkg::RES_W-1:0] status;

    // Shadow copy of the table contents
    dht_pkg::slot_state_t      ht_state [dht_pkg::SLOTS];
    logic [dht_pkg::KEY_W-1:0] ht_key   [dht_pkg::SLOTS];

    dht_pkg::res_t             status_due_q [$];
    logic [dht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                        n_err;
    int                        n_sent;
    int                        n_done;
    int                        res_seen [5];
    int                        stall_pct;

    double_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Probe i of the double hashing sequence
    function automatic int unsigned probe_slot_of(input logic [dht_pkg::KEY_W-1:0] k,
                                                  input int unsigned i);
        int unsigned kk;
        int unsigned home;
        int unsigned step;
        kk   = 32'(k);
        home = kk % dht_pkg::SLOTS;
        step = dht_pkg::STEP_MOD - kk % dht_pkg::STEP_MOD;
        return (home + i * step) % dht_pkg::SLOTS;
    endfunction

    // Apply one request to the shadow table and return the status it yields
    function automatic dht_pkg::res_t predict_status(input dht_pkg::op_t op,
                                                     input logic [dht_pkg::KEY_W-1:0] k);
        int unsigned s;
        bit          any_free;
        any_free = 1'b0;
        case (op) inside
            dht_pkg::OP_INSERT:
            begin
                for (int i = 0; i < dht_pkg::SLOTS; i++)
                begin
                    if (ht_state[i] != dht_pkg::SS_USED)
                        any_free = 1'b1;
                end
                if (!any_free)
                    return dht_pkg::RES_FULL;
                for (int i = 0; i < dht_pkg::SLOTS; i++)
                begin
                    s = probe_slot_of(k, i);
                    if (ht_state[s] != dht_pkg::SS_USED)
                    begin
                        ht_key[s]   = k;
                        ht_state[s] = dht_pkg::SS_USED;
                        return dht_pkg::RES_INSERTED;
                    end
                end
                return dht_pkg::RES_FULL;
            end
            dht_pkg::OP_REMOVE, dht_pkg::OP_SEARCH:
            begin
                // never-used home slot ends the lookup at once
                if (ht_state[probe_slot_of(k, 0)] == dht_pkg::SS_EMPTY)
                    return dht_pkg::RES_NOT_FOUND;
                for (int i = 0; i < dht_pkg::SLOTS; i++)
                begin
                    s = probe_slot_of(k, i);
                    if (ht_state[s] == dht_pkg::SS_USED && ht_key[s] == k)
                    begin
                        if (op == dht_pkg::OP_REMOVE)
                        begin
                            ht_state[s] = dht_pkg::SS_DELETED;
                            return dht_pkg::RES_REMOVED;
                        end
                        return dht_pkg::RES_FOUND;
                    end
                end
                return dht_pkg::RES_NOT_FOUND;
            end
            default:
                return dht_pkg::RES_NOT_FOUND;
        endcase
    endfunction

    // Mix of small colliding keys and full-width keys
    function automatic logic [dht_pkg::KEY_W-1:0] fresh_key();
        logic [dht_pkg::KEY_W-1:0] k;
        if ($urandom_range(0, 1) == 0)
            k = dht_pkg::KEY_W'($urandom_range(1, 60));
        else
            k = dht_pkg::KEY_W'($urandom);
        if (k == '0)
            k = dht_pkg::KEY_W'(1);
        return k;
    endfunction

    // Drive one request at the falling edge and hold it until accepted
    task automatic send_request(input dht_pkg::op_t op, input logic [dht_pkg::KEY_W-1:0] k,
                                input int idle_pct, input bit typed,
                                input dht_pkg::res_t typed_res);
        int            gap;
        dht_pkg::res_t due;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        due = predict_status(op, k);
        status_due_q.push_back(typed ? typed_res : due);
        n_sent++;
        @(negedge clk);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due_q.size() == 0)
            begin
                $error("unexpected result: status %0d with no request pending", status);
                n_err++;
            end
            else
            begin
                if (status !== status_due_q[0])
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           status_due_q[0], status);
                    n_err++;
                end
                void'(status_due_q.pop_front());
            end
            if (status < 5)
                res_seen[status]++;
            n_done++;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int                        sender_idle [N_PHASES];
        int                        recv_stall  [N_PHASES];
        int                        pick;
        dht_pkg::op_t              op;
        logic [dht_pkg::KEY_W-1:0] k;

        sender_idle = '{0, 63, 0, 17};
        recv_stall  = '{0, 0, 63, 17};
        n_err     = 0;
        n_sent    = 0;
        n_done    = 0;
        stall_pct = 0;
        res_seen  = '{default: 0};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = dht_pkg::OP_INSERT;
        key       = '0;
        out_ready = 1'b0;
        for (int i = 0; i < dht_pkg::SLOTS; i++)
        begin
            ht_state[i] = dht_pkg::SS_EMPTY;
            ht_key[i]   = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (dir_rows[r])
            send_request(dir_rows[r].op, dir_rows[r].k, 0, dir_rows[r].typed, dir_rows[r].res);

        // Random requests, one idling pattern per phase
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            stall_pct = recv_stall[ph];
            for (int n = 0; n < N_RANDOM / N_PHASES; n++)
            begin
                if (n % POOL_RENEW == 0)
                begin
                    foreach (key_pool[p])
                        key_pool[p] = fresh_key();
                end
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = dht_pkg::OP_INSERT;
                else if (pick < 65)
                    op = dht_pkg::OP_REMOVE;
                else if (pick < 95)
                    op = dht_pkg::OP_SEARCH;
                else
                    op = dht_pkg::OP_BAD;
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    k = fresh_key();
                send_request(op, k, sender_idle[ph], 1'b0, dht_pkg::RES_NOT_FOUND);
            end
        end
        in_valid <= 1'b0;
        stall_pct = 0;

        // Drain, then watch for stray results
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Ran %0d requests (%0d directed) through four idling patterns.",
                 n_sent, N_DIRECTED);
        $display("Results: inserted %0d, full %0d, removed %0d, not found %0d, found %0d.",
                 res_seen[dht_pkg::RES_INSERTED], res_seen[dht_pkg::RES_FULL],
                 res_seen[dht_pkg::RES_REMOVED], res_seen[dht_pkg::RES_NOT_FOUND],
                 res_seen[dht_pkg::RES_FOUND]);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Timeout: %0d requests sent, %0d results received", n_sent, n_done);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ double_hash_table.f @@
design/dht_pkg.sv
design/dht_ram.sv
design/dht_dp.sv
design/dht_ctrl.sv
design/double_hash_table.sv
test/tb_double_hash_table.sv
